@@ design/mrfp_pkg.sv @@
// Shared types, state codes and status codes of the Modbus response frame parser.
package mrfp_pkg;

  // parser state codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADDR  = 3'd1;
  localparam logic [2:0] ST_CODE  = 3'd2;
  localparam logic [2:0] ST_DATA  = 3'd3;
  localparam logic [2:0] ST_DATA2 = 3'd4;
  localparam logic [2:0] ST_CRCHI = 3'd5;
  localparam logic [2:0] ST_CRCLO = 3'd6;
  localparam logic [2:0] ST_WAIT  = 3'd7;

  // result status codes
  localparam logic [2:0] STS_ACCEPTED    = 3'd0;
  localparam logic [2:0] STS_ADDR_MISM   = 3'd1;
  localparam logic [2:0] STS_CODE_MISM   = 3'd2;
  localparam logic [2:0] STS_UNSUPPORTED = 3'd3;
  localparam logic [2:0] STS_IGNORED     = 3'd4;
  localparam logic [2:0] STS_COMPLETE    = 3'd5;

  // function codes
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_WRITE_COIL   = 8'd5;
  localparam logic [7:0] FC_WRITE_REG    = 8'd6;

  // data bytes of a write single coil / register response
  localparam logic [8:0] SINGLE_DATA_LEN = 9'd4;

  // configuration register indexes and reset values
  localparam logic [7:0] CFG_SLAVE_ADDR = 8'd0;
  localparam logic [7:0] CFG_FUNC_CODE  = 8'd1;
  localparam logic [7:0] SLAVE_ADDR_RST = 8'd0;
  localparam logic [7:0] FUNC_CODE_RST  = 8'd3;

  typedef struct packed {
    logic [2:0] state;
    logic [8:0] data_count;
    logic [7:0] byte_count;
    logic [7:0] frame_func;
    logic [7:0] crc_hi;
  } parse_ctx_t;

  typedef struct packed {
    logic [7:0] slave_addr;
    logic [7:0] func_code;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_index;
    logic [7:0]  data_byte;
    logic [15:0] received_crc;
    logic [2:0]  parser_state;
  } result_t;

endpackage

@@ design/mrfp_cfg_regs.sv @@
// Request match registers written through the configuration channel.
module mrfp_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic [7:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  output mrfp_pkg::cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_addr <= mrfp_pkg::SLAVE_ADDR_RST;
      cfg.func_code  <= mrfp_pkg::FUNC_CODE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == mrfp_pkg::CFG_SLAVE_ADDR) begin
        cfg.slave_addr <= cfg_data;
      end else if (cfg_index == mrfp_pkg::CFG_FUNC_CODE) begin
        cfg.func_code <= cfg_data;
      end
    end
  end

endmodule

@@ design/mrfp_step.sv @@
// Next-state and result logic for one received byte or restart request.
module mrfp_step (
  input  logic                 action,
  input  logic [7:0]           rx_byte,
  input  mrfp_pkg::cfg_t       cfg,
  input  mrfp_pkg::parse_ctx_t ctx,
  output mrfp_pkg::parse_ctx_t ctx_next,
  output mrfp_pkg::result_t    res
);

  logic [8:0] count_inc;
  logic [8:0] bc_plus1;

  assign count_inc = ctx.data_count + 9'd1;
  assign bc_plus1  = {1'b0, ctx.byte_count} + 9'd1;

  always_comb begin
    ctx_next         = ctx;
    res.status       = mrfp_pkg::STS_IGNORED;
    res.data_index   = 8'd0;
    res.data_byte    = 8'd0;
    res.received_crc = 16'd0;

    if (action) begin
      // restart: arm receiver from any state
      ctx_next.state      = mrfp_pkg::ST_ADDR;
      ctx_next.data_count = 9'd0;
      res.status          = mrfp_pkg::STS_ACCEPTED;
    end else begin
      case (ctx.state)
        mrfp_pkg::ST_ADDR: begin
          if (rx_byte == cfg.slave_addr) begin
            ctx_next.state = mrfp_pkg::ST_CODE;
            res.status     = mrfp_pkg::STS_ACCEPTED;
          end else begin
            ctx_next.state = mrfp_pkg::ST_WAIT;
            res.status     = mrfp_pkg::STS_ADDR_MISM;
          end
        end
        mrfp_pkg::ST_CODE: begin
          ctx_next.frame_func = rx_byte;
          if (rx_byte == cfg.func_code) begin
            ctx_next.state = mrfp_pkg::ST_DATA;
            res.status     = mrfp_pkg::STS_ACCEPTED;
          end else begin
            ctx_next.state = mrfp_pkg::ST_WAIT;
            res.status     = mrfp_pkg::STS_CODE_MISM;
          end
        end
        mrfp_pkg::ST_DATA: begin
          if (ctx.frame_func inside {mrfp_pkg::FC_WRITE_COIL, mrfp_pkg::FC_WRITE_REG}) begin
            res.data_index      = ctx.data_count[7:0];
            res.data_byte       = rx_byte;
            res.status          = mrfp_pkg::STS_ACCEPTED;
            ctx_next.data_count = count_inc;
            if (count_inc >= mrfp_pkg::SINGLE_DATA_LEN) begin
              ctx_next.state = mrfp_pkg::ST_CRCHI;
            end
          end else if (ctx.frame_func == mrfp_pkg::FC_READ_HOLDING) begin
            // byte count field, stored as a data byte too
            res.data_index      = ctx.data_count[7:0];
            res.data_byte       = rx_byte;
            res.status          = mrfp_pkg::STS_ACCEPTED;
            ctx_next.byte_count = rx_byte;
            ctx_next.data_count = count_inc;
            ctx_next.state      = (rx_byte != 8'd0) ? mrfp_pkg::ST_DATA2
                                                    : mrfp_pkg::ST_CRCHI;
          end else begin
            ctx_next.state = mrfp_pkg::ST_WAIT;
            res.status     = mrfp_pkg::STS_UNSUPPORTED;
          end
        end
        mrfp_pkg::ST_DATA2: begin
          if (ctx.frame_func == mrfp_pkg::FC_READ_HOLDING) begin
            res.data_index      = ctx.data_count[7:0];
            res.data_byte       = rx_byte;
            res.status          = mrfp_pkg::STS_ACCEPTED;
            ctx_next.data_count = count_inc;
            if (count_inc >= bc_plus1) begin
              ctx_next.state = mrfp_pkg::ST_CRCHI;
            end
          end else begin
            ctx_next.state = mrfp_pkg::ST_WAIT;
            res.status     = mrfp_pkg::STS_UNSUPPORTED;
          end
        end
        mrfp_pkg::ST_CRCHI: begin
          ctx_next.crc_hi = rx_byte;
          ctx_next.state  = mrfp_pkg::ST_CRCLO;
          res.status      = mrfp_pkg::STS_ACCEPTED;
        end
        mrfp_pkg::ST_CRCLO: begin
          res.received_crc = {ctx.crc_hi, rx_byte};
          ctx_next.state   = mrfp_pkg::ST_IDLE;
          res.status       = mrfp_pkg::STS_COMPLETE;
        end
        default: begin
          // idle or waiting: byte is dropped
          res.status = mrfp_pkg::STS_IGNORED;
        end
      endcase
    end

    res.parser_state = ctx_next.state;
  end

endmodule

@@ design/modbus_response_frame_parser.sv @@
// Modbus RTU response frame parser top level: input register, step logic, result register.
// A request accepted into the input register is parsed by the step logic, and its result
// loads into the result register, raising m_tvalid, once that register is free.
// Throughput: one request per cycle; a full result register that is not taken
// stalls the input register, and s_tready follows m_tready through that path.
// Reset (rst, synchronous): parser idle, counts cleared, match regs at 0 and 3, both empty.
module modbus_response_frame_parser (
  input  logic        clk,
  input  logic        rst,
  // receive side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] action (1 = restart receiver)
  // result side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] data_index, [15:8] data_byte,
                                 // [31:16] received_crc, [34:32] parser_state, [39:35] zero
  output logic [2:0]  m_tuser,   // [2:0] status
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index, // 0 slave address, 1 function code
  input  logic [7:0]  cfg_data
);

  mrfp_pkg::cfg_t       cfg;
  mrfp_pkg::parse_ctx_t ctx;
  mrfp_pkg::parse_ctx_t ctx_next;
  mrfp_pkg::result_t    res;
  mrfp_pkg::result_t    res_q;

  // input register
  logic       in_valid;
  logic       in_action;
  logic [7:0] in_byte;
  logic       out_free;
  logic       advance;

  // configuration writes are taken every cycle
  assign cfg_ready = 1'b1;

  mrfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mrfp_step u_step (
    .action   (in_action),
    .rx_byte  (in_byte),
    .cfg      (cfg),
    .ctx      (ctx),
    .ctx_next (ctx_next),
    .res      (res)
  );

  // result register can load when empty or being drained
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_action <= s_tuser;
      in_byte   <= s_tdata;
    end
  end

  // parser context commits when the request moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state      <= mrfp_pkg::ST_IDLE;
      ctx.data_count <= 9'd0;
      ctx.byte_count <= 8'd0;
      ctx.frame_func <= 8'd0;
      ctx.crc_hi     <= 8'd0;
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tuser = res_q.status;
  assign m_tdata = {5'd0, res_q.parser_state, res_q.received_crc,
                    res_q.data_byte, res_q.data_index};

endmodule

@@ sim/tb_top.sv @@
// Testbench for modbus_response_frame_parser: streamed response bytes checked against a model.
module tb_top;

  // One received byte or a restart, as the sender puts it on the s_* group
  typedef struct {
    bit         restart;
    logic [7:0] value;
  } rx_item_t;

  // Receiver ready patterns; each one holds for a random stretch of cycles
  typedef enum int {RX_FREE, RX_RANDOM, RX_THIRDS, RX_SPARSE} rx_pattern_e;

  // Parser model plus the queue of results it still expects from the block
  class frame_tracker;
    logic [7:0] match_addr;
    logic [7:0] match_code;
    logic [2:0] state;
    logic [8:0] data_count;
    logic [7:0] byte_count;
    logic [7:0] frame_func;
    logic [7:0] crc_hi;
    mrfp_pkg::result_t pending_results[$];
    int unsigned mismatches;
    int unsigned counted;   // requests taken

    function new();
      match_addr = mrfp_pkg::SLAVE_ADDR_RST;
      match_code = mrfp_pkg::FUNC_CODE_RST;
      state      = mrfp_pkg::ST_IDLE;
      data_count = '0;
      byte_count = '0;
      frame_func = '0;
      crc_hi     = '0;
      mismatches = 0;
      counted    = 0;
    endfunction

    function void set_register(logic [7:0] idx, logic [7:0] val);
      case (idx)
        mrfp_pkg::CFG_SLAVE_ADDR: match_addr = val;
        mrfp_pkg::CFG_FUNC_CODE:  match_code = val;
        default: ;
      endcase
    endfunction

    // Advance the model by one accepted request and queue its result
    function void take_request(bit restart, logic [7:0] b);
      mrfp_pkg::result_t r;
      r = '0;
      r.status = mrfp_pkg::STS_IGNORED;
      if (restart) begin
        state      = mrfp_pkg::ST_ADDR;
        data_count = '0;
        r.status   = mrfp_pkg::STS_ACCEPTED;
      end else begin
        case (state)
          mrfp_pkg::ST_ADDR: begin
            if (b == match_addr) begin
              state    = mrfp_pkg::ST_CODE;
              r.status = mrfp_pkg::STS_ACCEPTED;
            end else begin
              state    = mrfp_pkg::ST_WAIT;
              r.status = mrfp_pkg::STS_ADDR_MISM;
            end
          end
          mrfp_pkg::ST_CODE: begin
            frame_func = b;
            if (b == match_code) begin
              state    = mrfp_pkg::ST_DATA;
              r.status = mrfp_pkg::STS_ACCEPTED;
            end else begin
              state    = mrfp_pkg::ST_WAIT;
              r.status = mrfp_pkg::STS_CODE_MISM;
            end
          end
          mrfp_pkg::ST_DATA: begin
            if (frame_func == mrfp_pkg::FC_WRITE_COIL || frame_func == mrfp_pkg::FC_WRITE_REG) begin
              r.data_index = data_count[7:0];
              r.data_byte  = b;
              r.status     = mrfp_pkg::STS_ACCEPTED;
              data_count   = data_count + 9'd1;
              if (data_count >= mrfp_pkg::SINGLE_DATA_LEN) state = mrfp_pkg::ST_CRCHI;
            end else if (frame_func == mrfp_pkg::FC_READ_HOLDING) begin
              // first data byte is the byte count; zero goes straight to the CRC
              r.data_index = data_count[7:0];
              r.data_byte  = b;
              r.status     = mrfp_pkg::STS_ACCEPTED;
              byte_count   = b;
              data_count   = data_count + 9'd1;
              state        = (b != 8'd0) ? mrfp_pkg::ST_DATA2 : mrfp_pkg::ST_CRCHI;
            end else begin
              state    = mrfp_pkg::ST_WAIT;
              r.status = mrfp_pkg::STS_UNSUPPORTED;
            end
          end
          mrfp_pkg::ST_DATA2: begin
            if (frame_func == mrfp_pkg::FC_READ_HOLDING) begin
              r.data_index = data_count[7:0];
              r.data_byte  = b;
              r.status     = mrfp_pkg::STS_ACCEPTED;
              data_count   = data_count + 9'd1;
              // 9-bit compare: a count of 255 ends at data_count 256
              if (data_count >= {1'b0, byte_count} + 9'd1) state = mrfp_pkg::ST_CRCHI;
            end else begin
              state    = mrfp_pkg::ST_WAIT;
              r.status = mrfp_pkg::STS_UNSUPPORTED;
            end
          end
          mrfp_pkg::ST_CRCHI: begin
            crc_hi   = b;
            state    = mrfp_pkg::ST_CRCLO;
            r.status = mrfp_pkg::STS_ACCEPTED;
          end
          mrfp_pkg::ST_CRCLO: begin
            r.received_crc = {crc_hi, b};
            state          = mrfp_pkg::ST_IDLE;
            r.status       = mrfp_pkg::STS_COMPLETE;
          end
          default: ;   // idle and wait ignore bytes
        endcase
      end
      r.parser_state = state;
      counted++;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted result against the oldest expectation
    function void check_result(logic [2:0] sts, logic [39:0] word);
      mrfp_pkg::result_t e;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", sts);
        mismatches++;
        return;
      end
      e = pending_results.pop_front();
      compare_field("status", 16'(e.status), 16'(sts));
      compare_field("data_index", 16'(e.data_index), 16'(word[7:0]));
      compare_field("data_byte", 16'(e.data_byte), 16'(word[15:8]));
      compare_field("received_crc", e.received_crc, word[31:16]);
      compare_field("parser_state", 16'(e.parser_state), 16'(word[34:32]));
      compare_field("pad", 16'd0, 16'(word[39:35]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;     // [7:0] rx_byte
  logic        s_tuser = 1'b0;     // [0] action (restart)
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;            // [7:0] index, [15:8] byte, [31:16] crc, [34:32] state
  logic [2:0]  m_tuser;            // [2:0] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'd0;
  logic [7:0]  cfg_data = 8'd0;

  frame_tracker tracker = new();

  int          burst_left = 0;     // requests left in the current sender burst
  int          large_left = 1;     // full 255-byte read frames still allowed
  int          rx_left = 0;
  rx_pattern_e rx_mode = RX_FREE;
  int unsigned random_goal;

  modbus_response_frame_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: take results, and pick a new ready pattern every stretch.
  // The sparse pattern is the one that drives ready least often.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tuser, m_tdata);
    if (rx_left == 0) begin
      rx_mode = rx_pattern_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE:   m_tready <= 1'b1;
      RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
      RX_THIRDS: m_tready <= (rx_left % 3 == 0);
      default:   m_tready <= (rx_left % 8 == 0);
    endcase
  end

  // Sender: bursts of random length, with valid held low in a gap between them.
  // Valid stays high across back-to-back requests in a burst.
  task automatic send_request(bit restart, logic [7:0] value);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= restart;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_request(restart, value);
    burst_left--;
  endtask

  // Stop sending and let every outstanding result come back, plus pipeline slack
  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both match registers back to back; only called with the block drained
  task automatic program_match(logic [7:0] addr, logic [7:0] code);
    cfg_valid <= 1'b1;
    cfg_index <= mrfp_pkg::CFG_SLAVE_ADDR;
    cfg_data  <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_register(mrfp_pkg::CFG_SLAVE_ADDR, addr);
    cfg_index <= mrfp_pkg::CFG_FUNC_CODE;
    cfg_data  <= code;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_register(mrfp_pkg::CFG_FUNC_CODE, code);
    cfg_valid <= 1'b0;
  endtask

  // One response frame with random content; mostly well formed, sometimes
  // with a wrong address or code, cut short, or followed by a stray byte
  task automatic send_frame();
    rx_item_t   items[$];
    logic [7:0] code;
    logic [7:0] count;
    int         n_data;
    int         cut;
    items.push_back(rx_item_t'{1'b1, 8'($urandom)});
    items.push_back(rx_item_t'{1'b0,
                    ($urandom_range(0, 9) != 0) ? tracker.match_addr : 8'($urandom)});
    code = ($urandom_range(0, 9) != 0) ? tracker.match_code : 8'($urandom);
    items.push_back(rx_item_t'{1'b0, code});
    if (code == mrfp_pkg::FC_WRITE_COIL || code == mrfp_pkg::FC_WRITE_REG) begin
      n_data = 4;
    end else if (code == mrfp_pkg::FC_READ_HOLDING) begin
      if (large_left > 0 && $urandom_range(0, 9) == 0) begin
        count = 8'd255;
        large_left--;
      end else begin
        count = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 12));
      end
      items.push_back(rx_item_t'{1'b0, count});
      n_data = int'(count);
    end else begin
      n_data = $urandom_range(0, 2);
    end
    repeat (n_data) items.push_back(rx_item_t'{1'b0, 8'($urandom)});
    repeat (2) items.push_back(rx_item_t'{1'b0, 8'($urandom)});   // CRC hi, lo
    if ($urandom_range(0, 7) == 0) begin
      // truncated: the next frame's restart lands mid-frame
      cut = $urandom_range(1, items.size() - 1);
      while (items.size() > cut) void'(items.pop_back());
    end
    if ($urandom_range(0, 4) == 0) items.push_back(rx_item_t'{1'b0, 8'($urandom)});
    foreach (items[i]) send_request(items[i].restart, items[i].value);
  endtask

  initial begin
    logic [7:0] addr;
    logic [7:0] code;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset match values (address 0, read holding)
    send_request(1'b0, 8'hFF);             // byte while idle
    send_request(1'b1, 8'hFF);             // restart, byte content ignored
    send_request(1'b0, 8'h00);
    send_request(1'b0, mrfp_pkg::FC_READ_HOLDING);
    send_request(1'b0, 8'h00);             // zero byte count, CRC follows
    send_request(1'b0, 8'hFF);
    send_request(1'b0, 8'h00);             // frame complete
    send_request(1'b0, 8'hAA);             // idle again after completion
    drain_results();

    program_match(8'hFF, mrfp_pkg::FC_WRITE_COIL);
    send_request(1'b1, 8'h00);
    send_request(1'b0, 8'h12);             // address mismatch
    send_request(1'b0, 8'h55);             // ignored while waiting
    send_request(1'b1, 8'h5A);
    send_request(1'b0, 8'hFF);
    send_request(1'b0, mrfp_pkg::FC_WRITE_REG);    // code mismatch
    send_request(1'b1, 8'h00);
    send_request(1'b0, 8'hFF);
    send_request(1'b0, mrfp_pkg::FC_WRITE_COIL);
    send_request(1'b0, 8'h00);
    send_request(1'b0, 8'hFF);
    send_request(1'b0, 8'h0F);
    send_request(1'b0, 8'hF0);
    send_request(1'b0, 8'h00);
    send_request(1'b0, 8'hFF);
    drain_results();

    // Matching but unsupported code, with a register write between restart and address
    program_match(8'h01, 8'h10);
    send_request(1'b1, 8'h00);
    drain_results();
    program_match(8'h80, 8'h10);
    send_request(1'b0, 8'h80);
    send_request(1'b0, 8'h10);
    send_request(1'b0, 8'h33);
    drain_results();

    // Random phases: new match values each phase, extremes among them
    random_goal = tracker.counted + 520;
    while (tracker.counted < random_goal) begin
      drain_results();
      case ($urandom_range(0, 3))
        0:       addr = 8'h00;
        1:       addr = 8'hFF;
        default: addr = 8'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0, 1, 2: code = mrfp_pkg::FC_READ_HOLDING;
        3:       code = mrfp_pkg::FC_WRITE_COIL;
        4:       code = mrfp_pkg::FC_WRITE_REG;
        5:       code = 8'h00;
        6:       code = 8'hFF;
        default: code = 8'($urandom);
      endcase
      program_match(addr, code);
      repeat ($urandom_range(3, 10)) begin
        if ($urandom_range(0, 9) == 0) send_request(1'b0, 8'($urandom));
        else send_frame();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
design/mrfp_pkg.sv
design/mrfp_cfg_regs.sv
design/mrfp_step.sv
design/modbus_response_frame_parser.sv
sim/tb_top.sv
